@@ rtl/rth_pkg.sv @@
// ----------------------------------------------------------------------------
// rth_pkg
// Shared types and constants for the RGB to HSV pipeline.
// ----------------------------------------------------------------------------
package rth_pkg;

  localparam int unsigned ChanW        = 8;
  localparam int unsigned DivStages    = 4;  // divider pipeline stages
  localparam int unsigned StepsPerStage = 2; // restoring steps per stage

  localparam logic [ChanW-1:0] HueOfsRed   = 8'd0;
  localparam logic [ChanW-1:0] HueOfsGreen = 8'd85;
  localparam logic [ChanW-1:0] HueOfsBlue  = 8'd171;
  localparam logic [ChanW-1:0] HueSector   = 8'd43;

  // Restoring divider state: {rem, lo} shifts left one bit per step,
  // quotient bits enter lo from the bottom.
  typedef struct packed {
    logic [ChanW-1:0] rem;
    logic [ChanW-1:0] lo;
    logic [ChanW-1:0] den;
  } div_t;

  typedef struct packed {
    div_t             sat;   // 255*chroma / value
    div_t             hue;   // 43*|diff| / chroma
    logic             neg;   // hue quotient is negative
    logic [ChanW-1:0] offs;  // hue sector offset
    logic [ChanW-1:0] val;   // channel maximum
  } pix_t;

endpackage

@@ rtl/rth_front.sv @@
// ----------------------------------------------------------------------------
// rth_front
// First stage: max/min, hue sector, and divider operands.
// ----------------------------------------------------------------------------
module rth_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [7:0]    red_i,
  input  logic [7:0]    green_i,
  input  logic [7:0]    blue_i,
  output logic          valid_o,
  output rth_pkg::pix_t stage_o
);
  import rth_pkg::*;

  logic [ChanW-1:0]   mx, mn, chroma, mag;
  logic [ChanW:0]     num, num_abs;
  logic [ChanW-1:0]   offs;
  logic [2*ChanW-1:0] sat_dvd, hue_dvd;
  logic               valid_q;
  pix_t               stage_d, stage_q;

  always_comb begin
    mx = (red_i > green_i) ? ((red_i > blue_i) ? red_i : blue_i)
                           : ((green_i > blue_i) ? green_i : blue_i);
    mn = (red_i < green_i) ? ((red_i < blue_i) ? red_i : blue_i)
                           : ((green_i < blue_i) ? green_i : blue_i);
    chroma = mx - mn;

    // ties: red first, then green
    if (mx == red_i) begin
      offs = HueOfsRed;
      num  = {1'b0, green_i} - {1'b0, blue_i};
    end else if (mx == green_i) begin
      offs = HueOfsGreen;
      num  = {1'b0, blue_i} - {1'b0, red_i};
    end else begin
      offs = HueOfsBlue;
      num  = {1'b0, red_i} - {1'b0, green_i};
    end
    num_abs = num[ChanW] ? (~num + 1'b1) : num;
    mag     = num_abs[ChanW-1:0];

    sat_dvd = {chroma, 8'd0} - {8'd0, chroma};    // 255 * chroma
    hue_dvd = {8'd0, mag} * {8'd0, HueSector};    // 43 * |diff|

    stage_d.sat.rem = sat_dvd[2*ChanW-1:ChanW];
    stage_d.sat.lo  = sat_dvd[ChanW-1:0];
    stage_d.sat.den = mx;
    stage_d.hue.rem = hue_dvd[2*ChanW-1:ChanW];
    stage_d.hue.lo  = hue_dvd[ChanW-1:0];
    stage_d.hue.den = chroma;
    stage_d.neg     = num[ChanW];
    stage_d.offs    = offs;
    stage_d.val     = mx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

@@ rtl/rth_div_stage.sv @@
// ----------------------------------------------------------------------------
// rth_div_stage
// One divider stage: two restoring steps on both quotients.
// ----------------------------------------------------------------------------
module rth_div_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  rth_pkg::pix_t stage_i,
  output logic          valid_o,
  output rth_pkg::pix_t stage_o
);
  import rth_pkg::*;

  function automatic div_t div_step(input div_t s);
    logic [ChanW:0] t;
    logic           ge;
    div_t           r;
    t      = {s.rem, s.lo[ChanW-1]};
    ge     = (t >= {1'b0, s.den});
    r      = s;
    r.rem  = ge ? 8'(t - {1'b0, s.den}) : t[ChanW-1:0];
    r.lo   = {s.lo[ChanW-2:0], ge};
    return r;
  endfunction

  logic valid_q;
  pix_t stage_d, stage_q;

  always_comb begin
    stage_d = stage_i;
    for (int i = 0; i < StepsPerStage; i++) begin
      stage_d.sat = div_step(stage_d.sat);
      stage_d.hue = div_step(stage_d.hue);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

@@ rtl/rth_back.sv @@
// ----------------------------------------------------------------------------
// rth_back
// Last stage: sign, hue offset, black and grey cases, output register.
// ----------------------------------------------------------------------------
module rth_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  rth_pkg::pix_t stage_i,
  output logic          valid_o,
  output logic [7:0]    hue_o,
  output logic [7:0]    sat_o,
  output logic [7:0]    val_o
);
  import rth_pkg::*;

  logic             valid_q;
  logic [ChanW-1:0] hue_d, sat_d, val_d, hue_q, sat_q, val_q, q_signed;

  always_comb begin
    q_signed = stage_i.neg ? (~stage_i.hue.lo + 1'b1) : stage_i.hue.lo;
    hue_d    = stage_i.offs + q_signed;
    sat_d    = stage_i.sat.lo;
    val_d    = stage_i.val;
    if (stage_i.val == '0) begin
      // black pixel
      hue_d = '0;
      sat_d = '0;
    end else if (stage_i.sat.lo == '0) begin
      // grey pixel
      hue_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      val_q <= val_d;
    end
  end

  assign valid_o = valid_q;
  assign hue_o   = hue_q;
  assign sat_o   = sat_q;
  assign val_o   = val_q;

endmodule

@@ rtl/rgb_to_hsv_converter.sv @@
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// 8-bit RGB to 8-bit HSV pixel converter, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one RGB pixel per clock unless the output stalls and returns hue,
// saturation and value, one result per request, in order. Stages: one front
// stage (max/min, sector pick and the two dividends), four divider stages
// (two restoring steps each on both the saturation and the hue quotient),
// and the output register. Each stage holds its own valid bit and advances
// whenever it is empty or the stage after it advances, so bubbles close up
// and a stalled output holds the pipeline without losing or repeating a
// pixel. s_axis_tready depends on m_axis_tready only when every stage holds
// a pixel.
// Value is max(R,G,B); saturation is 255*(max-min)/max truncated; hue is a
// sector offset (0 red, 85 green, 171 blue; ties favor red, then green) plus
// 43*diff/chroma truncated toward zero, modulo 256. Black gives all zeros,
// grey gives hue and saturation zero.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // hue [7:0], saturation [15:8],
                                      // brightness [23:16]
);
  import rth_pkg::*;

  // stage 0 is the front register, 1..DivStages the divider stages
  logic             valid  [DivStages+1];
  pix_t             stage  [DivStages+1];
  logic             en     [DivStages+1];
  logic             en_back;
  logic [ChanW-1:0] hue, sat, val;

  // advance when empty or when the downstream stage advances
  assign en_back = !m_axis_tvalid || m_axis_tready;
  assign en[DivStages] = !valid[DivStages] || en_back;
  for (genvar k = 0; k < DivStages; k++) begin : g_en
    assign en[k] = !valid[k] || en[k+1];
  end
  assign s_axis_tready = en[0];

  rth_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[0]),
    .valid_i (s_axis_tvalid),
    .red_i   (s_axis_tdata[7:0]),
    .green_i (s_axis_tdata[15:8]),
    .blue_i  (s_axis_tdata[23:16]),
    .valid_o (valid[0]),
    .stage_o (stage[0])
  );

  for (genvar k = 0; k < DivStages; k++) begin : g_div
    rth_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en[k+1]),
      .valid_i (valid[k]),
      .stage_i (stage[k]),
      .valid_o (valid[k+1]),
      .stage_o (stage[k+1])
    );
  end

  rth_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_back),
    .valid_i (valid[DivStages]),
    .stage_i (stage[DivStages]),
    .valid_o (m_axis_tvalid),
    .hue_o   (hue),
    .sat_o   (sat),
    .val_o   (val)
  );

  assign m_axis_tdata = {val, sat, hue};

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rgb_to_hsv_converter: an in-bench HSV predictor is
// compared field by field against every output request, under random idle
// bursts on both streams, a long output hold-off and a back-to-back stream.
// ----------------------------------------------------------------------------
module testbench;
  import rth_pkg::*;

  localparam int HalfPeriod  = 6;
  localparam int ResetCycles = 11;
  localparam int WatchLimit  = 3000;  // cycles with no request moving
  localparam int TailCycles  = 20;    // pipeline is six deep
  localparam int HoldCycles  = 200;   // long output hold-off
  localparam int MaxReported = 10;
  localparam int FullScale   = 255;

  typedef logic [ChanW-1:0] chan_t;

  // Packed so that hue lands in the low byte, matching m_axis_tdata.
  typedef struct packed {
    chan_t brightness;
    chan_t saturation;
    chan_t hue;
  } hsv_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // red [7:0], green [15:8], blue [23:16]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // hue [7:0], saturation [15:8], brightness [23:16]

  rgb_to_hsv_converter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Results predicted for accepted pixels, oldest first.
  hsv_t pending_hsv[$];

  int unsigned mismatches;
  int unsigned pixels_in;
  int unsigned results_ok;
  int unsigned n_black;
  int unsigned n_grey;
  int unsigned n_neg_hue;
  int unsigned stall_run;
  int unsigned longest_stall;
  int unsigned idle_cycles;

  // Knobs shared by the test tasks and the stream processes.
  bit src_idle_en;
  bit rx_idle_en;
  int unsigned rx_hold_reqs;   // bumped by a test to start one long hold-off

  always begin
    clk_i = 1'b0;
    #HalfPeriod;
    clk_i = 1'b1;
    #HalfPeriod;
  end

  // --------------------------------------------------------------------------
  // Predictor: value is the channel max, saturation 255*chroma/value,
  // hue = sector offset + 43*diff/chroma (signed, toward zero), mod 256.
  // --------------------------------------------------------------------------
  function automatic hsv_t rgb_to_hsv(chan_t r, chan_t g, chan_t b);
    hsv_t res;
    int   mx;
    int   mn;
    int   chroma;
    int   sat;
    int   diff;
    int   quot;
    int   offs;
    res = '0;
    mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
    mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
    if (mx == 0) return res;            // black: everything zero
    chroma = mx - mn;
    sat = (FullScale * chroma) / mx;
    res.brightness = chan_t'(mx);
    if (sat == 0) return res;           // grey: hue and saturation zero
    res.saturation = chan_t'(sat);
    // Sector pick, ties go to red and then to green.
    if (mx == int'(r)) begin
      offs = int'(HueOfsRed);
      diff = int'(g) - int'(b);
    end else if (mx == int'(g)) begin
      offs = int'(HueOfsGreen);
      diff = int'(b) - int'(r);
    end else begin
      offs = int'(HueOfsBlue);
      diff = int'(r) - int'(g);
    end
    quot = (int'(HueSector) * diff) / chroma;  // int division truncates to zero
    res.hue = chan_t'(offs + quot);
    return res;
  endfunction

  task automatic log_mismatch(string what, hsv_t want, hsv_t got);
    mismatches++;
    if (mismatches <= MaxReported)
      $display("[%0t] mismatch (%s): expected h=%0d s=%0d v=%0d, got h=%0d s=%0d v=%0d",
               $time, what, want.hue, want.saturation, want.brightness,
               got.hue, got.saturation, got.brightness);
  endtask

  // --------------------------------------------------------------------------
  // Monitor and checker. Samples at the edge, so it sees pre-edge values of
  // every request. Output is popped before input is pushed.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : scoreboard
    hsv_t want;
    hsv_t got;
    string bad;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = hsv_t'(m_axis_tdata);
        if (pending_hsv.size() == 0) begin
          log_mismatch("output with nothing pending", '0, got);
        end else begin
          want = pending_hsv.pop_front();
          bad = "";
          if (got.hue != want.hue)               bad = {bad, " hue"};
          if (got.saturation != want.saturation) bad = {bad, " saturation"};
          if (got.brightness != want.brightness) bad = {bad, " brightness"};
          if (bad != "") log_mismatch({"field", bad}, want, got);
          else           results_ok++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = rgb_to_hsv(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]);
        pending_hsv.push_back(want);
        pixels_in++;
        if (want.brightness == 0)      n_black++;
        else if (want.saturation == 0) n_grey++;
        // a negative hue quotient shows up as a hue below its sector start
        else if (want.hue > 8'd213 || (want.hue < HueOfsBlue && want.hue > 8'd128) ||
                 (want.hue < HueOfsGreen && want.hue > 8'd43))
          n_neg_hue++;
      end
      // input side stalled by the block
      if (s_axis_tvalid && !s_axis_tready) begin
        stall_run++;
        if (stall_run > longest_stall) longest_stall = stall_run;
      end else begin
        stall_run = 0;
      end
    end
  end

  // Watchdog: no request moving on either side for too long ends the run.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("[%0t] watchdog: no request moved for %0d cycles", $time, WatchLimit);
      $display("** rgb_to_hsv_converter: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Output side: random stall bursts, or a long hold-off counted down here.
  // --------------------------------------------------------------------------
  initial begin : output_sink
    int unsigned burst;
    int unsigned hold_left;
    int unsigned holds_seen;
    burst      = 0;
    hold_left  = 0;
    holds_seen = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_reqs != holds_seen) begin
        holds_seen = rx_hold_reqs;
        hold_left  = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        m_axis_tready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 18) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side. Called just after an edge; returns at the edge where the
  // request is taken, leaving tvalid high for a following pixel.
  // --------------------------------------------------------------------------
  task automatic send_pixel(chan_t r, chan_t g, chan_t b);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 24'($urandom);   // junk while idle
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, g, r};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Sender pause: idle until every pending result has come back.
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_hsv.size() != 0) @(posedge clk_i);
  endtask

  // Uniform pixels half the time, the rest greys, ties and tiny chroma.
  task automatic send_random_pixel();
    chan_t v;
    chan_t lo;
    v  = chan_t'($urandom_range(1, 255));
    lo = chan_t'($urandom_range(0, v));
    case ($urandom_range(0, 9))
      0: send_pixel(v, v, v);
      1: send_pixel(v, v, lo);
      2: send_pixel(lo, v, v);
      3: send_pixel(v, lo, v);
      4: send_pixel(v - chan_t'($urandom_range(0, v > 2 ? 2 : v)),
                    v - chan_t'($urandom_range(0, v > 2 ? 2 : v)), v);
      default: send_pixel(chan_t'($urandom), chan_t'($urandom), chan_t'($urandom));
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    src_idle_en = 1'b1;
    rx_idle_en  = 1'b1;
    send_pixel(8'd0,   8'd0,   8'd0);     // black
    send_pixel(8'd255, 8'd255, 8'd255);   // white
    send_pixel(8'd1,   8'd1,   8'd1);     // dimmest grey
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0,   8'd0);     // pure primaries
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd1,   8'd0,   8'd0);     // smallest value, full saturation
    send_pixel(8'd0,   8'd1,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd255, 8'd255, 8'd0);     // red/green tie goes to red
    send_pixel(8'd0,   8'd255, 8'd255);   // green/blue tie goes to green
    send_pixel(8'd255, 8'd0,   8'd255);   // red/blue tie, hue wraps below zero
    send_pixel(8'd255, 8'd0,   8'd1);     // red, negative difference, quotient truncates to zero
    send_pixel(8'd10,  8'd200, 8'd5);     // green, negative quotient
    send_pixel(8'd0,   8'd5,   8'd200);   // blue, negative quotient
    send_pixel(8'd200, 8'd5,   8'd0);     // red, positive quotient
    send_pixel(8'd255, 8'd254, 8'd254);   // chroma of one
    send_pixel(8'd254, 8'd255, 8'd254);
    send_pixel(8'd254, 8'd254, 8'd255);
    send_pixel(8'd255, 8'd128, 8'd0);
    send_pixel(8'd0,   8'd128, 8'd255);
    send_pixel(8'd170, 8'd85,  8'd255);
    wait_drain();
  endtask

  task automatic test_random();
    src_idle_en = 1'b1;
    rx_idle_en  = 1'b1;
    repeat (560) send_random_pixel();
  endtask

  // Output held off for a long stretch while input keeps offering, so the
  // pipeline fills and input stalls; then the sender pauses until drained.
  task automatic test_backpressure();
    src_idle_en = 1'b0;
    rx_idle_en  = 1'b0;
    rx_hold_reqs++;
    repeat (40) send_random_pixel();
    wait_drain();
  endtask

  // Last part: back-to-back, no idling on either side.
  task automatic test_streaming();
    src_idle_en = 1'b0;
    rx_idle_en  = 1'b0;
    repeat (180) send_random_pixel();
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    src_idle_en   = 1'b0;
    rx_idle_en    = 1'b0;
    rx_hold_reqs  = 0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random();
    test_backpressure();
    test_streaming();

    wait_drain();
    repeat (TailCycles) @(posedge clk_i);   // catch any stray output
    if (pending_hsv.size() != 0) begin
      mismatches++;
      $display("%0d results never arrived", pending_hsv.size());
    end

    $display("Converted %0d pixels (%0d black, %0d grey, %0d with negative hue step),",
             pixels_in, n_black, n_grey, n_neg_hue);
    $display("%0d results matched; longest input stall %0d cycles, %0d mismatches.",
             results_ok, longest_stall, mismatches);
    if (mismatches == 0) begin
      $display("** rgb_to_hsv_converter: PASSED **");
    end else begin
      $display("** rgb_to_hsv_converter: FAILED **");
    end
    $finish;
  end

endmodule
